// ===== rtl/svpl_pkg.sv =====
// Package for the SNMP varbind list parser: tag and length constants, the
// parser phase, result kinds and the result burst that moves from front to back.
// No dependencies.
`default_nettype none

package svpl_pkg;

  localparam logic [7:0] TAG_SEQ  = 8'h30;
  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_STR  = 8'h04;
  localparam logic [7:0] TAG_NULL = 8'h05;
  localparam logic [7:0] TAG_OID  = 8'h06;

  localparam logic [7:0] INT_MAX_LEN   = 8'd4;
  localparam logic [2:0] ARC_MAX_BYTES = 3'd5;
  localparam logic [2:0] MAX_RES       = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LIST_LEN  = 4'd1,
    PH_BIND_TAG  = 4'd2,
    PH_BIND_LEN  = 4'd3,
    PH_NAME_TAG  = 4'd4,
    PH_NAME_LEN  = 4'd5,
    PH_NAME_1ST  = 4'd6,
    PH_NAME_REST = 4'd7,
    PH_VAL_TAG   = 4'd8,
    PH_VAL_LEN   = 4'd9,
    PH_INT_BODY  = 4'd10,
    PH_STR_BODY  = 4'd11,
    PH_OID_1ST   = 4'd12,
    PH_OID_REST  = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    VT_NULL = 2'd0,
    VT_INT  = 2'd1,
    VT_STR  = 2'd2,
    VT_OID  = 2'd3
  } vtag_t;

  typedef enum logic [2:0] {
    K_NAME_ARC = 3'd0,
    K_VAL_ARC  = 3'd1,
    K_INT      = 3'd2,
    K_STR      = 3'd3,
    K_NULL     = 3'd4,
    K_BIND_END = 3'd5,
    K_LIST_END = 3'd6,
    K_ERROR    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  idx;
  } res_t;

  // All results caused by one input byte, in order; cnt is 1 to 4 when pushed.
  typedef struct packed {
    logic [2:0]     cnt;
    res_t [3:0]     res;
  } burst_t;

  typedef struct packed {
    logic   valid;
    burst_t burst;
  } push_t;

  function automatic burst_t add_res(burst_t bst, kind_t kind, logic [31:0] value,
                                     logic [7:0] idx);
    burst_t r;
    r = bst;
    if (r.cnt < MAX_RES) begin
      r.res[r.cnt[1:0]].kind  = kind;
      r.res[r.cnt[1:0]].value = value;
      r.res[r.cnt[1:0]].idx   = idx;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/svpl_ifs.sv =====
// Channel interfaces of the SNMP varbind list parser: raw input bytes and
// decoded result items. Standalone; no package needed.
`default_nettype none

interface svpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_list;
  modport source (output valid, data_byte, start_list, input ready);
  modport sink (input valid, data_byte, start_list, output ready);
endinterface

interface svpl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [7:0]  binding_index;
  logic        last;
  modport source (output valid, kind, value, binding_index, last, input ready);
  modport sink (input valid, kind, value, binding_index, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/svpl_front.sv =====
// Front end of the varbind parser: takes one byte per cycle while the queue is not full,
// runs the BER phase machine and packs the results of each byte into one burst.
// Depends on svpl_pkg and svpl_in_if.
`default_nettype none

module svpl_front (
  input  logic             clk,
  input  logic             rst_n,
  svpl_in_if.sink          in_ch,
  input  logic             q_full,
  output svpl_pkg::push_t  push
);
  import svpl_pkg::*;

  typedef struct packed {
    logic fail;
    logic empty_end;
    logic arc_res;
    logic int_res;
    logic str_res;
    logic null_res;
    logic bind_end;
    logic list_end;
  } dec_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  list_rem_r, list_rem_nxt;
  logic [7:0]  field_rem_r, field_rem_nxt;
  vtag_t       vtag_r, vtag_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  arc_cnt_r, arc_cnt_nxt;
  logic [7:0]  bind_cnt_r, bind_cnt_nxt;

  dec_t        dec;
  burst_t      burst;
  logic        take;
  logic        start;
  logic [7:0]  b;
  logic        body_ph;
  logic [7:0]  lr_dec;
  logic [7:0]  fr_dec;
  logic        fr_zero;
  logic        arc_long;
  logic        oid_value;
  logic        oid_first;
  logic [31:0] acc7;
  logic [31:0] acc8;
  logic        lt40;
  logic        lt80;
  logic [31:0] arc_top;
  logic [31:0] arc_sub;
  kind_t       arc_kind;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign start       = in_ch.start_list;
  assign b           = in_ch.data_byte;

  assign body_ph   = (phase_r >= PH_BIND_TAG) && (phase_r <= PH_OID_REST);
  assign lr_dec    = list_rem_r - 8'd1;
  assign fr_dec    = field_rem_r - 8'd1;
  assign fr_zero   = (fr_dec == 8'd0);
  assign arc_long  = (arc_cnt_r >= ARC_MAX_BYTES);
  assign oid_value = (phase_r == PH_OID_1ST) || (phase_r == PH_OID_REST);
  assign oid_first = (phase_r == PH_OID_1ST) || (phase_r == PH_NAME_1ST);
  assign arc_kind  = oid_value ? K_VAL_ARC : K_NAME_ARC;
  assign acc7      = {acc_r[24:0], b[6:0]};
  assign acc8      = {acc_r[23:0], b};

  // The first subidentifier carries two arcs.
  assign lt40    = (acc7 < 32'd40);
  assign lt80    = (acc7 < 32'd80);
  assign arc_top = lt40 ? 32'd0 : (lt80 ? 32'd1 : 32'd2);
  assign arc_sub = acc7 - (lt40 ? 32'd0 : (lt80 ? 32'd40 : 32'd80));

  always_comb begin
    dec = '0;
    if (start) begin
      dec.fail = (b != TAG_SEQ);
    end else if (body_ph && (list_rem_r == 8'd0)) begin
      dec.fail = 1'b1;
    end else begin
      unique case (phase_r) inside
        PH_LIST_LEN: begin
          dec.fail      = b[7];
          dec.empty_end = (b == 8'd0);
        end
        PH_BIND_TAG: dec.fail = (b != TAG_SEQ);
        PH_BIND_LEN: dec.fail = b[7];
        PH_NAME_TAG: dec.fail = (b != TAG_OID);
        PH_NAME_LEN, PH_VAL_LEN: begin
          if (b[7]) begin
            dec.fail = 1'b1;
          end else if ((phase_r == PH_NAME_LEN) || (vtag_r == VT_OID)) begin
            dec.fail = (b == 8'd0);
          end else begin
            case (vtag_r)
              VT_INT: dec.fail = (b == 8'd0) || (b > INT_MAX_LEN);
              VT_STR: dec.bind_end = (b == 8'd0);
              default: begin
                dec.fail     = (b != 8'd0);
                dec.null_res = (b == 8'd0);
                dec.bind_end = (b == 8'd0);
              end
            endcase
          end
        end
        PH_VAL_TAG: begin
          dec.fail = !((b == TAG_INT) || (b == TAG_STR) || (b == TAG_NULL) ||
                       (b == TAG_OID));
        end
        PH_NAME_1ST, PH_NAME_REST, PH_OID_1ST, PH_OID_REST: begin
          dec.fail     = arc_long || (b[7] && fr_zero);
          dec.arc_res  = !arc_long && !b[7];
          dec.bind_end = !arc_long && !b[7] && oid_value && fr_zero;
        end
        PH_INT_BODY: begin
          dec.int_res  = fr_zero;
          dec.bind_end = fr_zero;
        end
        PH_STR_BODY: begin
          dec.str_res  = 1'b1;
          dec.bind_end = fr_zero;
        end
        default: ;
      endcase
    end
    dec.list_end = dec.bind_end && (lr_dec == 8'd0);
  end

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (start) begin
        phase_nxt = dec.fail ? PH_IDLE : PH_LIST_LEN;
      end else if (dec.fail) begin
        phase_nxt = PH_IDLE;
      end else if (dec.bind_end) begin
        phase_nxt = dec.list_end ? PH_IDLE : PH_BIND_TAG;
      end else begin
        unique case (phase_r) inside
          PH_LIST_LEN: phase_nxt = dec.empty_end ? PH_IDLE : PH_BIND_TAG;
          PH_BIND_TAG: phase_nxt = PH_BIND_LEN;
          PH_BIND_LEN: phase_nxt = PH_NAME_TAG;
          PH_NAME_TAG: phase_nxt = PH_NAME_LEN;
          PH_NAME_LEN: phase_nxt = PH_NAME_1ST;
          PH_VAL_TAG:  phase_nxt = PH_VAL_LEN;
          PH_VAL_LEN: begin
            case (vtag_r)
              VT_OID:  phase_nxt = PH_OID_1ST;
              VT_INT:  phase_nxt = PH_INT_BODY;
              VT_STR:  phase_nxt = PH_STR_BODY;
              default: phase_nxt = PH_IDLE;
            endcase
          end
          PH_NAME_1ST, PH_NAME_REST: begin
            if (dec.arc_res) begin
              phase_nxt = fr_zero ? PH_VAL_TAG : PH_NAME_REST;
            end
          end
          PH_OID_1ST, PH_OID_REST: begin
            if (dec.arc_res) begin
              phase_nxt = PH_OID_REST;
            end
          end
          PH_INT_BODY, PH_STR_BODY: phase_nxt = phase_r;
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    list_rem_nxt  = list_rem_r;
    field_rem_nxt = field_rem_r;
    vtag_nxt      = vtag_r;
    acc_nxt       = acc_r;
    arc_cnt_nxt   = arc_cnt_r;
    bind_cnt_nxt  = bind_cnt_r;
    burst         = '0;
    if (take) begin
      if (start) begin
        list_rem_nxt  = 8'd0;
        field_rem_nxt = 8'd0;
        vtag_nxt      = VT_NULL;
        acc_nxt       = 32'd0;
        arc_cnt_nxt   = 3'd0;
        bind_cnt_nxt  = 8'd0;
        if (dec.fail) begin
          burst = add_res(burst, K_ERROR, 32'd0, 8'd0);
        end
      end else begin
        if (body_ph && (list_rem_r != 8'd0)) begin
          list_rem_nxt = lr_dec;
        end
        case (phase_r)
          PH_LIST_LEN: begin
            if (!b[7]) begin
              list_rem_nxt = b;
            end
          end
          PH_NAME_LEN, PH_VAL_LEN: begin
            if (!b[7] && !(body_ph && (list_rem_r == 8'd0))) begin
              field_rem_nxt = b;
              acc_nxt       = 32'd0;
              arc_cnt_nxt   = 3'd0;
            end
          end
          PH_VAL_TAG: begin
            if (b == TAG_INT) begin
              vtag_nxt = VT_INT;
            end else if (b == TAG_STR) begin
              vtag_nxt = VT_STR;
            end else if (b == TAG_NULL) begin
              vtag_nxt = VT_NULL;
            end else if (b == TAG_OID) begin
              vtag_nxt = VT_OID;
            end
          end
          PH_NAME_1ST, PH_NAME_REST, PH_OID_1ST, PH_OID_REST: begin
            if (list_rem_r != 8'd0) begin
              field_rem_nxt = fr_dec;
              if (!arc_long) begin
                if (b[7]) begin
                  acc_nxt     = acc7;
                  arc_cnt_nxt = arc_cnt_r + 3'd1;
                end else begin
                  acc_nxt     = 32'd0;
                  arc_cnt_nxt = 3'd0;
                end
              end
            end
          end
          PH_INT_BODY: begin
            if (list_rem_r != 8'd0) begin
              field_rem_nxt = fr_dec;
              acc_nxt       = fr_zero ? 32'd0 : acc8;
            end
          end
          PH_STR_BODY: begin
            if (list_rem_r != 8'd0) begin
              field_rem_nxt = fr_dec;
            end
          end
          default: ;
        endcase

        if (dec.fail) begin
          burst = add_res(burst, K_ERROR, 32'd0, bind_cnt_r);
        end
        if (dec.arc_res) begin
          if (oid_first) begin
            burst = add_res(burst, arc_kind, arc_top, bind_cnt_r);
            burst = add_res(burst, arc_kind, arc_sub, bind_cnt_r);
          end else begin
            burst = add_res(burst, arc_kind, acc7, bind_cnt_r);
          end
        end
        if (dec.int_res) begin
          burst = add_res(burst, K_INT, acc8, bind_cnt_r);
        end
        if (dec.str_res) begin
          burst = add_res(burst, K_STR, {24'd0, b}, bind_cnt_r);
        end
        if (dec.null_res) begin
          burst = add_res(burst, K_NULL, 32'd0, bind_cnt_r);
        end
        if (dec.empty_end) begin
          burst = add_res(burst, K_LIST_END, 32'd0, bind_cnt_r);
        end
        if (dec.bind_end) begin
          bind_cnt_nxt = bind_cnt_r + 8'd1;
          burst = add_res(burst, K_BIND_END, 32'd0, bind_cnt_r);
        end
        if (dec.list_end) begin
          burst = add_res(burst, K_LIST_END, 32'd0, bind_cnt_r + 8'd1);
        end
      end
    end
  end

  assign push.valid = take && (burst.cnt != 3'd0);
  assign push.burst = burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      list_rem_r  <= 8'd0;
      field_rem_r <= 8'd0;
      vtag_r      <= VT_NULL;
      acc_r       <= 32'd0;
      arc_cnt_r   <= 3'd0;
      bind_cnt_r  <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      list_rem_r  <= list_rem_nxt;
      field_rem_r <= field_rem_nxt;
      vtag_r      <= vtag_nxt;
      acc_r       <= acc_nxt;
      arc_cnt_r   <= arc_cnt_nxt;
      bind_cnt_r  <= bind_cnt_nxt;
    end
  end

  // A byte that arrives while idle and does not start a list is dropped silently.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && !start && (phase_r == PH_IDLE)) |-> !push.valid)
    else $error("idle byte produced results");

endmodule

`default_nettype wire

// ===== rtl/svpl_queue.sv =====
// Short queue of result bursts between the parser front and the output back.
// Depends on svpl_pkg.
`default_nettype none

module svpl_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  svpl_pkg::push_t  push,
  output logic             full,
  output svpl_pkg::burst_t head,
  output logic             head_valid,
  input  logic             pop
);
  import svpl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  burst_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push.burst;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !full)
    else $error("burst pushed into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> ((push.burst.cnt != 3'd0) && (push.burst.cnt <= MAX_RES)))
    else $error("burst count out of range");

endmodule

`default_nettype wire

// ===== rtl/svpl_back.sv =====
// Back end of the varbind parser: walks the head burst one result per cycle into the
// output register while that register is empty or taken. Depends on svpl_pkg and svpl_out_if.
`default_nettype none

module svpl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  svpl_pkg::burst_t head,
  input  logic             head_valid,
  output logic             pop,
  svpl_out_if.source       out_ch
);
  import svpl_pkg::*;

  logic [1:0]  slot_r, slot_nxt;
  logic        valid_r, valid_nxt;
  kind_t       kind_r;
  logic [31:0] value_r;
  logic [7:0]  idx_r;
  logic        last_r;
  logic        load;
  logic        last_slot;
  res_t        cur;

  assign cur       = head.res[slot_r];
  assign last_slot = ((head.cnt - 3'd1) == {1'b0, slot_r});
  assign load      = head_valid && (!valid_r || out_ch.ready);
  assign pop       = load && last_slot;

  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      slot_nxt  = last_slot ? 2'd0 : slot_r + 2'd1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= cur.kind;
      value_r <= cur.value;
      idx_r   <= cur.idx;
      last_r  <= last_slot;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.value         = value_r;
  assign out_ch.binding_index = idx_r;
  assign out_ch.last          = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, slot_r} < head.cnt))
    else $error("result slot beyond burst length");

endmodule

`default_nettype wire

// ===== rtl/snmp_varbind_list_parser.sv =====
// SNMPv1 BER varbind list parser, one byte per input item.
// in_ch carries data_byte and start_list; start_list restarts parsing at that byte.
// out_ch carries decoded items: kind, value, binding_index and last, where last
// marks the final result caused by one input byte (one to four results per byte).
// Both channels move an item on a rising clock edge with valid and ready high.
// The front accepts one byte every cycle while the burst queue has room; the
// back delivers one result per cycle while the receiver is ready. Each byte's
// burst is written into the queue when the byte is accepted; its first result is
// then loaded into the output register, from which the receiver takes it.
// QUEUE_DEPTH bursts can wait between front and back; when it is full the input
// ready drops. A stalled receiver keeps the output item stable, the queue fills,
// and then the input stalls as well; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and the output register and
// leaves the parser idle, ignoring bytes until one arrives with start_list set.
// Depends on svpl_pkg, svpl_ifs, svpl_front, svpl_queue and svpl_back.
`default_nettype none

module snmp_varbind_list_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  svpl_in_if.sink     in_ch,
  svpl_out_if.source  out_ch
);
  import svpl_pkg::*;

  push_t  push;
  logic   q_full;
  burst_t head;
  logic   head_valid;
  logic   pop;

  svpl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  svpl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  svpl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
